// ===== src/pyd_pkg.sv =====
package pyd_pkg;

  localparam int MAX_GROUPS = 1024;
  localparam int COL_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int GPR_W      = 11;
  localparam int EFF_W      = (COL_W + 1 > GPR_W) ? COL_W + 1 : GPR_W;
  localparam int WORD_W     = 32;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [GPR_W-1:0] GPR_RESET = GPR_W'(320);

  // register index, taken from paddr bit 2
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_GPR    = 1'b1;

  localparam logic MODE_UYVY = 1'b0;
  localparam logic MODE_YUYV = 1'b1;

  localparam logic [7:0] Y_SCALE  = 8'd219;
  localparam logic [7:0] C_SCALE  = 8'd224;
  localparam logic [7:0] Y_OFFSET = 8'd16;
  localparam logic [7:0] C_OFFSET = 8'd128;

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] luma_out;
    logic [7:0] cb_out;
    logic [7:0] cr_out;
    logic       row_end;
  } out_word_t;

  typedef struct packed {
    logic s2_load;
    logic out_load;
  } pipe_ctl_t;

endpackage

// ===== src/pyd_store.sv =====
module pyd_store (
  input  logic                            clk,
  input  logic                            en,
  input  logic                            we,
  input  logic [pyd_pkg::COL_W-1:0]       addr,
  input  logic [pyd_pkg::WORD_W-1:0]      wdata,
  output logic [pyd_pkg::WORD_W-1:0]      rdata
);

  logic [pyd_pkg::WORD_W-1:0] mem [pyd_pkg::MAX_GROUPS];
  logic [pyd_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/pyd_math.sv =====
module pyd_math (
  input  logic                        clk,
  input  pyd_pkg::pipe_ctl_t          ctl,
  input  logic [pyd_pkg::WORD_W-1:0]  cur_word,
  input  logic [pyd_pkg::WORD_W-1:0]  up_word,
  input  logic                        mode,
  input  logic                        last,
  output pyd_pkg::out_word_t          out_data
);

  function automatic logic [9:0] div255(input logic [17:0] x);
    logic [25:0] p;
    logic [9:0]  q;
    logic [17:0] r;
    begin
      p = {x, 8'd0} + 26'(x);
      q = p[25:16];
      r = x - ({q, 8'd0} - 18'(q));
      if (r >= 18'd255) begin
        q = q + 10'd1;
      end
      return q;
    end
  endfunction

  function automatic logic [7:0] chroma_fin(input logic [15:0] m, input logic neg);
    logic [9:0] q;
    logic [7:0] h;
    begin
      q = div255(18'(m));
      h = 8'(q >> 1);
      return neg ? (pyd_pkg::C_OFFSET - h) : (pyd_pkg::C_OFFSET + h);
    end
  endfunction

  // stage two: sums and scaling products
  logic        s2_mode_r, s2_last_r;
  logic [7:0]  s2_y0_r, s2_cb0_r, s2_cr0_r;
  logic [17:0] s2_xy_r;
  logic [15:0] s2_mu_r, s2_mv_r;
  logic        s2_su_r, s2_sv_r;

  logic [7:0]  ga, gb, gc, gd, ua, ub, uc, ud;
  logic [9:0]  lsum0, ysum1;
  logic [8:0]  cbsum0, crsum0;
  logic signed [8:0] us, vs;
  logic [8:0]  au, av;

  assign {gd, gc, gb, ga} = cur_word;
  assign {ud, uc, ub, ua} = up_word;

  always_comb begin
    lsum0  = 10'(gb) + 10'(ub) + 10'(gd) + 10'(ud);
    cbsum0 = 9'(ga) + 9'(ua);
    crsum0 = 9'(gc) + 9'(uc);
    ysum1  = 10'(ga) + 10'(ua) + 10'(gc) + 10'(uc);
    us     = $signed({gb[7], gb}) + $signed({ub[7], ub});
    vs     = $signed({gd[7], gd}) + $signed({ud[7], ud});
    au     = us[8] ? 9'(-us) : 9'(us);
    av     = vs[8] ? 9'(-vs) : 9'(vs);
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      s2_mode_r <= mode;
      s2_last_r <= last;
      s2_y0_r   <= lsum0[9:2];
      s2_cb0_r  <= cbsum0[8:1];
      s2_cr0_r  <= crsum0[8:1];
      s2_xy_r   <= 18'(ysum1) * 18'(pyd_pkg::Y_SCALE);
      s2_mu_r   <= 16'(au) * 16'(pyd_pkg::C_SCALE);
      s2_mv_r   <= 16'(av) * 16'(pyd_pkg::C_SCALE);
      s2_su_r   <= us[8];
      s2_sv_r   <= vs[8];
    end
  end

  // output stage: divide by 255 and offset in YUYV mode, plain averages in UYVY mode
  pyd_pkg::out_word_t out_r, out_nxt;
  logic [9:0] qy;

  always_comb begin
    qy = div255(s2_xy_r);
    out_nxt.row_end = s2_last_r;
    unique case (s2_mode_r)
      pyd_pkg::MODE_UYVY: begin
        out_nxt.luma_out = s2_y0_r;
        out_nxt.cb_out   = s2_cb0_r;
        out_nxt.cr_out   = s2_cr0_r;
      end
      pyd_pkg::MODE_YUYV: begin
        out_nxt.luma_out = 8'(qy >> 2) + pyd_pkg::Y_OFFSET;
        out_nxt.cb_out   = chroma_fin(s2_mu_r, s2_su_r);
        out_nxt.cr_out   = chroma_fin(s2_mv_r, s2_sv_r);
      end
      default: begin
        out_nxt.luma_out = s2_y0_r;
        out_nxt.cb_out   = s2_cb0_r;
        out_nxt.cr_out   = s2_cr0_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ===== src/packed_yuv422_half_downsampler.sv =====
// Packed 4:2:2 to half-resolution 4:4:4 downsampler. One four-byte word (two
// pixels) is accepted per clock unless out_stall has filled the pipeline and
// in_stall is raised. The single-port 1024 x 32 line store sees exactly one
// access per word: even source rows write it, odd source rows read the word
// above. An odd-row word gives its pixel on out_valid after the store read at
// the accepting edge, then sums and scaling products, then divide-by-255 and
// offset (y,u,y,v mode); even-row words give nothing, so an unpaired last row
// of a frame is dropped. The store needs no clearing after reset, since
// every entry is written by an even row before an odd row reads it. Registers:
// 0x0 format_mode (0 = u,y,v,y; 1 = y,u,y,v with signed chroma and rescale to
// video range), 0x4 groups_per_row (1..1024, 0 acts as 1); write them only
// while the block is idle.
module packed_yuv422_half_downsampler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pyd_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pyd_pkg::out_word_t            out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pyd_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [pyd_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [pyd_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  // configuration
  logic                      mode_r;
  logic [pyd_pkg::GPR_W-1:0] gpr_r;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pyd_pkg::MODE_UYVY;
      gpr_r  <= pyd_pkg::GPR_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        pyd_pkg::REG_FORMAT: mode_r <= cfg_pwdata[0];
        pyd_pkg::REG_GPR:    gpr_r  <= cfg_pwdata[pyd_pkg::GPR_W-1:0];
        default:             mode_r <= mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      pyd_pkg::REG_FORMAT: cfg_prdata = pyd_pkg::CFG_DW'(mode_r);
      pyd_pkg::REG_GPR:    cfg_prdata = pyd_pkg::CFG_DW'(gpr_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // row width clamp
  logic [pyd_pkg::EFF_W-1:0] eff_gpr;

  always_comb begin
    if (gpr_r == '0) begin
      eff_gpr = pyd_pkg::EFF_W'(1);
    end else if (32'(gpr_r) > 32'(pyd_pkg::MAX_GROUPS)) begin
      eff_gpr = pyd_pkg::EFF_W'(pyd_pkg::MAX_GROUPS);
    end else begin
      eff_gpr = pyd_pkg::EFF_W'(gpr_r);
    end
  end

  // handshake and pipeline valids
  logic s1_valid_r, s1_valid_nxt;
  logic s2_valid_r, s2_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_adv, s2_adv, s1_adv, in_acc;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s2_adv   = !s2_valid_r || out_adv;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // column and row parity
  logic [pyd_pkg::COL_W-1:0] col_r, col_nxt, col_cur;
  logic                      odd_r, odd_nxt, odd_cur, last_cur;

  always_comb begin
    col_cur = in_data.frame_start ? '0 : col_r;
    odd_cur = in_data.frame_start ? 1'b0 : odd_r;
    if (pyd_pkg::EFF_W'(col_cur) >= eff_gpr) begin
      col_cur = '0;
    end
    last_cur = (pyd_pkg::EFF_W'(col_cur) == eff_gpr - pyd_pkg::EFF_W'(1));
  end

  always_comb begin
    col_nxt = col_r;
    odd_nxt = odd_r;
    if (in_acc) begin
      if (last_cur) begin
        col_nxt = '0;
        odd_nxt = !odd_cur;
      end else begin
        col_nxt = col_cur + pyd_pkg::COL_W'(1);
        odd_nxt = odd_cur;
      end
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_adv  ? (in_acc && odd_cur) : s1_valid_r;
    s2_valid_nxt  = s2_adv  ? s1_valid_r : s2_valid_r;
    out_valid_nxt = out_adv ? s2_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      odd_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      odd_r       <= odd_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // store access stage
  logic [pyd_pkg::WORD_W-1:0] in_word;
  logic [pyd_pkg::WORD_W-1:0] s1_word_r, up_word;
  logic                       s1_mode_r, s1_last_r;

  assign in_word = {in_data.byte_d, in_data.byte_c, in_data.byte_b, in_data.byte_a};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= in_word;
      s1_mode_r <= mode_r;
      s1_last_r <= last_cur;
    end
  end

  pyd_store u_store (
    .clk   (clk),
    .en    (in_acc),
    .we    (!odd_cur),
    .addr  (col_cur),
    .wdata (in_word),
    .rdata (up_word)
  );

  pyd_pkg::pipe_ctl_t ctl;

  always_comb begin
    ctl.s2_load  = s2_adv && s1_valid_r;
    ctl.out_load = out_adv && s2_valid_r;
  end

  pyd_math u_math (
    .clk      (clk),
    .ctl      (ctl),
    .cur_word (s1_word_r),
    .up_word  (up_word),
    .mode     (s1_mode_r),
    .last     (s1_last_r),
    .out_data (out_data)
  );

  assign out_valid = out_valid_r;

  // stall only when every stage holds a word that cannot move
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && out_valid_r))
    else $error("input stalled with a free pipeline stage");

  // a blocked word in the first stage is not lost
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_adv) |=> s1_valid_r)
    else $error("blocked stage one word dropped");

  // only odd-row words enter the result pipeline
  a_odd_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (s1_valid_r == $past(odd_cur)))
    else $error("result pipeline entry does not follow row parity");

endmodule
